// ===== src/gsa_pkg.sv =====
// gsa_pkg: widths, stage indices, status codes and the side-band struct of the
// glide-slope altitude pipeline. No dependencies.
package gsa_pkg;

  localparam int COORD_W = 48;
  localparam int DIF_W   = COORD_W + 1;

  localparam int PP_W  = 32;
  localparam int MA_W  = 256;
  localparam int MB_W  = 128;
  localparam int MP_W  = MA_W + MB_W;
  localparam int MUL_LAT = 7;

  localparam int N_W   = 2 * DIF_W + 1;
  localparam int NN_W  = 2 * N_W + 2;
  localparam int DOT_W = N_W + DIF_W + 2;
  localparam int T_W   = NN_W + DIF_W + 1;
  localparam int NUM_W = T_W + DIF_W + 1;
  localparam int DEN_W = NN_W + DIF_W + 1;

  localparam int QB      = COORD_W + 3;
  localparam int DIV_W   = DEN_W + QB + 4;
  localparam int DIV_LAT = QB + 1;
  localparam int RES_W   = QB + 2;

  localparam int I_P1   = MUL_LAT + 1;
  localparam int I_P2   = 2 * MUL_LAT + 2;
  localparam int I_P3   = 3 * MUL_LAT + 3;
  localparam int I_P4   = 4 * MUL_LAT + 4;
  localparam int I_P5   = 4 * MUL_LAT + 5;
  localparam int I_END  = I_P5 + DIV_LAT;
  localparam int SIDE_N = I_END + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_ZRUN  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic                      valid;
    logic                      zrun;
    logic                      degen;
    logic                      neg;
    logic signed [COORD_W-1:0] az;
    logic signed [DIF_W-1:0]   ac0;
    logic signed [DIF_W-1:0]   ac1;
    logic signed [DIF_W-1:0]   ac2;
    logic signed [DIF_W-1:0]   as0;
    logic signed [DIF_W-1:0]   as2;
  } side_t;

endpackage

// ===== src/gsa_mul.sv =====
// gsa_mul: signed 256 x 128 multiplier, 32x32 partial products and an adder tree.
// Depends on gsa_pkg. Advances on en.
module gsa_mul import gsa_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] p
);

  localparam int NA = MA_W / PP_W;
  localparam int NB = MB_W / PP_W;

  logic [MA_W-1:0]      am_r;
  logic [MB_W-1:0]      bm_r;
  logic [MUL_LAT-2:0]   sg_r;
  logic [2*PP_W-1:0]    pp_r [NA][NB];
  logic [MP_W-1:0]      row_nxt [NA];
  logic [MP_W-1:0]      row_r [NA];
  logic [MP_W-1:0]      pair_r [NA/2];
  logic [MP_W-1:0]      quad_r [NA/4];
  logic [MP_W-1:0]      mag_r;
  logic signed [MP_W-1:0] p_r;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (MP_W'(pp_r[i][j]) << ((i + j) * PP_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r <= a[MA_W-1] ? (~a + 1'b1) : a;
      bm_r <= b[MB_W-1] ? (~b + 1'b1) : b;
      sg_r <= {sg_r[MUL_LAT-3:0], a[MA_W-1] ^ b[MB_W-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= am_r[i*PP_W +: PP_W] * bm_r[j*PP_W +: PP_W];
        end
        row_r[i] <= row_nxt[i];
      end
      for (int k = 0; k < NA/2; k++) pair_r[k] <= row_r[2*k] + row_r[2*k+1];
      for (int k = 0; k < NA/4; k++) quad_r[k] <= pair_r[2*k] + pair_r[2*k+1];
      mag_r <= quad_r[0] + quad_r[1];
      p_r   <= sg_r[MUL_LAT-2] ? (~mag_r + 1'b1) : mag_r;
    end
  end

  assign p = p_r;

endmodule

// ===== src/gsa_div.sv =====
// gsa_div: pipelined restoring divider, one quotient bit per stage, plus a
// quotient overflow check up front. Depends on gsa_pkg.
module gsa_div import gsa_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [QB-1:0]    q,
  output logic             ovf
);

  logic [DIV_W-1:0] rem_r [QB];
  logic [DIV_W-1:0] dv_r  [QB];
  logic [QB-1:0]    q_r   [DIV_LAT];
  logic             ovf_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      dv_r[0]  <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num >= (den << QB);
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [DIV_W-1:0] sh;
    logic             ge;
    assign sh = dv_r[s-1] << (QB - s);
    assign ge = rem_r[s-1] >= sh;
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= q_r[s-1] | ({{(QB-1){1'b0}}, ge} << (QB - s));
        ovf_r[s] <= ovf_r[s-1];
      end
    end
    if (s < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? rem_r[s-1] - sh : rem_r[s-1];
          dv_r[s]  <= dv_r[s-1];
        end
      end
    end
  end

  assign q   = q_r[QB];
  assign ovf = ovf_r[QB];

endmodule

// ===== src/glide_slope_altitude.sv =====
// glide_slope_altitude: projects the current point onto the landing plane and
// returns the glide-slope altitude there. Depends on gsa_pkg, gsa_mul, gsa_div.
//
//   channel | ports                             | dir
//   in      | in_valid, in_stall, 12 coords     | beat in
//   out     | out_valid, out_stall, alt, status | beat out
//
// One beat per cycle while in_stall is low.
// Each beat passes four chained multiplier rounds, each followed by a register,
// and the 52-stage divider. Reset clears the valid bits only.
// While out holds a beat and out_stall is high the whole pipe freezes and
// in_stall rises; otherwise every stage advances.
module glide_slope_altitude import gsa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_current_x,
  input  logic signed [COORD_W-1:0] in_current_y,
  input  logic signed [COORD_W-1:0] in_current_z,
  input  logic signed [COORD_W-1:0] in_aim_x,
  input  logic signed [COORD_W-1:0] in_aim_y,
  input  logic signed [COORD_W-1:0] in_aim_z,
  input  logic signed [COORD_W-1:0] in_cross_x,
  input  logic signed [COORD_W-1:0] in_cross_y,
  input  logic signed [COORD_W-1:0] in_cross_z,
  input  logic signed [COORD_W-1:0] in_stop_x,
  input  logic signed [COORD_W-1:0] in_stop_y,
  input  logic signed [COORD_W-1:0] in_stop_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_slope_altitude,
  output logic [1:0]                out_status
);

  logic adv;

  logic signed [COORD_W-1:0] cur [3];
  logic signed [COORD_W-1:0] aim [3];
  logic signed [COORD_W-1:0] crs [3];
  logic signed [COORD_W-1:0] stp [3];
  logic signed [DIF_W-1:0]   ai_nxt [3];
  logic signed [DIF_W-1:0]   as_nxt [3];
  logic signed [DIF_W-1:0]   ac_nxt [3];
  logic signed [DIF_W-1:0]   ai_r [3];
  logic signed [DIF_W-1:0]   as_r [3];

  side_t side0;
  side_t side_nxt [SIDE_N];
  side_t side_r [SIDE_N];
  side_t side_e;

  logic signed [MP_W-1:0]  t1_p [3];
  logic signed [MP_W-1:0]  u1_p [3];
  logic signed [N_W-1:0]   n_r [3];
  logic signed [MP_W-1:0]  sq_p [3];
  logic signed [MP_W-1:0]  nd_p [3];
  logic signed [MP_W-1:0]  nn_nxt;
  logic signed [NN_W-1:0]  nn_r;
  logic signed [DOT_W-1:0] dot_r;
  logic signed [N_W-1:0]   n0d_r [MUL_LAT];
  logic signed [N_W-1:0]   n0_r;
  logic signed [MP_W-1:0]  a3_p, b3_p, c3_p, c3_abs;
  logic signed [T_W-1:0]   t_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        dend_r [MUL_LAT];
  logic signed [MP_W-1:0]  num_p, num_abs;
  logic [NUM_W-1:0]        anum_r;
  logic [DEN_W-1:0]        den4_r;
  logic [DIV_W-1:0]        num2_r, den2_r;
  logic [QB-1:0]           q;
  logic                    ovf;

  logic signed [RES_W-1:0]   res;
  logic                      fits;
  logic [COORD_W-1:0]        alt_nxt;
  logic [1:0]                st_nxt;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_alt_r;
  logic [1:0]                out_st_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign cur[0] = in_current_x;  assign cur[1] = in_current_y;  assign cur[2] = in_current_z;
  assign aim[0] = in_aim_x;      assign aim[1] = in_aim_y;      assign aim[2] = in_aim_z;
  assign crs[0] = in_cross_x;    assign crs[1] = in_cross_y;    assign crs[2] = in_cross_z;
  assign stp[0] = in_stop_x;     assign stp[1] = in_stop_y;     assign stp[2] = in_stop_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ai_nxt[i] = DIF_W'(crs[i]) - DIF_W'(aim[i]);
      as_nxt[i] = DIF_W'(stp[i]) - DIF_W'(aim[i]);
      ac_nxt[i] = DIF_W'(cur[i]) - DIF_W'(aim[i]);
    end
    side0       = '0;
    side0.valid = in_valid;
    side0.zrun  = (as_nxt[0] == '0);
    side0.az    = aim[2];
    side0.ac0   = ac_nxt[0];
    side0.ac1   = ac_nxt[1];
    side0.ac2   = ac_nxt[2];
    side0.as0   = as_nxt[0];
    side0.as2   = as_nxt[2];
  end

  always_comb begin
    side_nxt[0] = side0;
    for (int k = 1; k < SIDE_N; k++) side_nxt[k] = side_r[k-1];
    side_nxt[I_P2].degen = (nn_nxt == '0);
    side_nxt[I_P4].neg   = num_p[MP_W-1] ^ side_r[I_P4-1].as0[DIF_W-1];
  end

  // side band travels with every beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SIDE_N; k++) side_r[k].valid <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < SIDE_N; k++) side_r[k] <= side_nxt[k];
    end
  end

  // plane normal: n = AI x AS
  for (genvar i = 0; i < 3; i++) begin : g_cross
    gsa_mul u_t (.clk, .en(adv), .a(MA_W'(ai_r[(i+1)%3])), .b(MB_W'(as_r[(i+2)%3])),
                 .p(t1_p[i]));
    gsa_mul u_u (.clk, .en(adv), .a(MA_W'(ai_r[(i+2)%3])), .b(MB_W'(as_r[(i+1)%3])),
                 .p(u1_p[i]));
    gsa_mul u_sq (.clk, .en(adv), .a(MA_W'(n_r[i])), .b(MB_W'(n_r[i])), .p(sq_p[i]));
  end

  gsa_mul u_nd0 (.clk, .en(adv), .a(MA_W'(n_r[0])), .b(MB_W'(side_r[I_P1].ac0)), .p(nd_p[0]));
  gsa_mul u_nd1 (.clk, .en(adv), .a(MA_W'(n_r[1])), .b(MB_W'(side_r[I_P1].ac1)), .p(nd_p[1]));
  gsa_mul u_nd2 (.clk, .en(adv), .a(MA_W'(n_r[2])), .b(MB_W'(side_r[I_P1].ac2)), .p(nd_p[2]));

  assign nn_nxt = sq_p[0] + sq_p[1] + sq_p[2];

  gsa_mul u_a3 (.clk, .en(adv), .a(MA_W'(nn_r)), .b(MB_W'(side_r[I_P2].ac0)), .p(a3_p));
  gsa_mul u_b3 (.clk, .en(adv), .a(MA_W'(dot_r)), .b(MB_W'(n0_r)), .p(b3_p));
  gsa_mul u_c3 (.clk, .en(adv), .a(MA_W'(nn_r)), .b(MB_W'(side_r[I_P2].as0)), .p(c3_p));
  gsa_mul u_n4 (.clk, .en(adv), .a(MA_W'(t_r)), .b(MB_W'(side_r[I_P3].as2)), .p(num_p));

  assign c3_abs  = c3_p[MP_W-1] ? -c3_p : c3_p;
  assign num_abs = num_p[MP_W-1] ? -num_p : num_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ai_r[i] <= ai_nxt[i];
        as_r[i] <= as_nxt[i];
        n_r[i]  <= N_W'(t1_p[i] - u1_p[i]);
      end
      nn_r  <= NN_W'(nn_nxt);
      dot_r <= DOT_W'(nd_p[0] + nd_p[1] + nd_p[2]);
      n0d_r[0]  <= n_r[0];
      dend_r[0] <= den_r;
      for (int k = 1; k < MUL_LAT; k++) begin
        n0d_r[k]  <= n0d_r[k-1];
        dend_r[k] <= dend_r[k-1];
      end
      n0_r   <= n0d_r[MUL_LAT-1];
      t_r    <= T_W'(a3_p - b3_p);
      den_r  <= DEN_W'(c3_abs);
      anum_r <= NUM_W'(num_abs);
      den4_r <= dend_r[MUL_LAT-1];
      num2_r <= (DIV_W'(anum_r) << 1) + DIV_W'(den4_r);
      den2_r <= DIV_W'(den4_r) << 1;
    end
  end

  gsa_div u_div (.clk, .en(adv), .num(num2_r), .den(den2_r), .q, .ovf);

  assign side_e = side_r[I_END];
  assign res    = side_e.neg ? RES_W'(side_e.az) - $signed({2'b00, q})
                             : RES_W'(side_e.az) + $signed({2'b00, q});
  assign fits   = (res[RES_W-1:COORD_W-1] == '0) || (res[RES_W-1:COORD_W-1] == '1);

  always_comb begin
    alt_nxt = res[COORD_W-1:0];
    st_nxt  = ST_OK;
    if (side_e.degen) begin
      alt_nxt = '0;
      st_nxt  = ST_DEGEN;
    end else if (side_e.zrun) begin
      alt_nxt = '0;
      st_nxt  = ST_ZRUN;
    end else if (ovf) begin
      alt_nxt = side_e.neg ? SAT_MIN : SAT_MAX;
      st_nxt  = ST_SAT;
    end else if (!fits) begin
      alt_nxt = res[RES_W-1] ? SAT_MIN : SAT_MAX;
      st_nxt  = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_e.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && side_e.valid) begin
      out_alt_r <= alt_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slope_altitude = out_alt_r;
  assign out_status         = out_st_r;

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_SAT |->
      out_alt_r == SAT_MAX || out_alt_r == SAT_MIN)
    else $error("saturated beat not clamped");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_DEGEN || out_st_r == ST_ZRUN) |-> out_alt_r == '0)
    else $error("degenerate beat with nonzero altitude");

  a_end_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    side_e.valid && adv |=> out_valid_r)
    else $error("finished beat lost at output register");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    side_r[I_P5].valid && !side_r[I_P5].degen && !side_r[I_P5].zrun |-> den2_r != '0)
    else $error("zero divisor on a regular beat");

endmodule

// ===== bench/gsa_altitude_checker.sv =====
// gsa_altitude_checker: watches both channels of glide_slope_altitude, predicts
// each slope altitude and status, and compares results in order. Needs gsa_pkg.
module gsa_altitude_checker import gsa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_current_x,
  input  logic signed [COORD_W-1:0] in_current_y,
  input  logic signed [COORD_W-1:0] in_current_z,
  input  logic signed [COORD_W-1:0] in_aim_x,
  input  logic signed [COORD_W-1:0] in_aim_y,
  input  logic signed [COORD_W-1:0] in_aim_z,
  input  logic signed [COORD_W-1:0] in_cross_x,
  input  logic signed [COORD_W-1:0] in_cross_y,
  input  logic signed [COORD_W-1:0] in_cross_z,
  input  logic signed [COORD_W-1:0] in_stop_x,
  input  logic signed [COORD_W-1:0] in_stop_y,
  input  logic signed [COORD_W-1:0] in_stop_z,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_slope_altitude,
  input  logic [1:0]                out_status,
  output int                        mismatches,
  output int                        pending
);

  typedef logic signed [511:0] wide_t;
  typedef struct packed {
    logic signed [COORD_W-1:0] alt;
    logic [1:0]                status;
  } slope_t;

  slope_t expected_slopes[$];

  function automatic wide_t ext(input logic signed [COORD_W-1:0] v);
    return {{(512-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic slope_t glide_altitude(input wide_t c[3], input wide_t a[3],
                                            input wide_t x[3], input wide_t s[3]);
    wide_t ai[3], as[3], ac[3], n[3];
    wide_t nn, dot, t, num, den, res;
    logic [511:0] un, ud, uq;
    logic neg;
    slope_t r;
    for (int k = 0; k < 3; k++) begin
      ai[k] = x[k] - a[k];
      as[k] = s[k] - a[k];
      ac[k] = c[k] - a[k];
    end
    for (int k = 0; k < 3; k++)
      n[k] = ai[(k+1)%3] * as[(k+2)%3] - ai[(k+2)%3] * as[(k+1)%3];
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    dot = n[0]*ac[0] + n[1]*ac[1] + n[2]*ac[2];
    r.alt = '0;
    if (nn == 0) begin
      r.status = ST_DEGEN;
      return r;
    end
    if (as[0] == 0) begin
      r.status = ST_ZRUN;
      return r;
    end
    t = ac[0]*nn - n[0]*dot;
    num = as[2] * t;
    neg = num[511] ^ as[0][511];
    if (num[511]) num = -num;
    den = nn * (as[0][511] ? -as[0] : as[0]);
    un = 2*num + den;
    ud = 2*den;
    uq = un / ud;
    res = neg ? a[2] - wide_t'(uq) : a[2] + wide_t'(uq);
    if (res == ext(res[COORD_W-1:0])) begin
      r.alt = res[COORD_W-1:0];
      r.status = ST_OK;
    end else begin
      r.alt = res[511] ? SAT_MIN : SAT_MAX;
      r.status = ST_SAT;
    end
    return r;
  endfunction

  assign pending = expected_slopes.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    wide_t c[3], a[3], x[3], s[3];
    slope_t e;
    if (rst_n && in_valid && !in_stall) begin
      c = '{ext(in_current_x), ext(in_current_y), ext(in_current_z)};
      a = '{ext(in_aim_x), ext(in_aim_y), ext(in_aim_z)};
      x = '{ext(in_cross_x), ext(in_cross_y), ext(in_cross_z)};
      s = '{ext(in_stop_x), ext(in_stop_y), ext(in_stop_z)};
      expected_slopes.push_back(glide_altitude(c, a, x, s));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_slopes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: alt %0d status %0d", out_slope_altitude, out_status);
      end else begin
        e = expected_slopes.pop_front();
        if (e.alt !== out_slope_altitude || e.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected alt %0d status %0d, got alt %0d status %0d",
                     e.alt, e.status, out_slope_altitude, out_status);
        end
      end
    end
  end

endmodule

// ===== bench/tb_glide_slope_altitude.sv =====
// tb_glide_slope_altitude: drives directed and random point sets into
// glide_slope_altitude with random idling and gives the verdict.
// Needs gsa_pkg, the block and gsa_altitude_checker.
module tb_glide_slope_altitude;
  import gsa_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t pts[12];
  coord_t drv[12];
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_slope_altitude;
  logic [1:0] out_status;
  int     mismatches, pending;
  int     send_idle_pct = 9;
  int     recv_idle_pct = 77;
  logic   hold_req = 1'b0;

  initial for (int k = 0; k < 12; k++) drv[k] = '0;

  always #6 clk = ~clk;

  glide_slope_altitude dut (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_current_x(drv[0]), .in_current_y(drv[1]), .in_current_z(drv[2]),
    .in_aim_x(drv[3]), .in_aim_y(drv[4]), .in_aim_z(drv[5]),
    .in_cross_x(drv[6]), .in_cross_y(drv[7]), .in_cross_z(drv[8]),
    .in_stop_x(drv[9]), .in_stop_y(drv[10]), .in_stop_z(drv[11]),
    .out_valid, .out_stall, .out_slope_altitude, .out_status
  );

  gsa_altitude_checker chk (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_current_x(drv[0]), .in_current_y(drv[1]), .in_current_z(drv[2]),
    .in_aim_x(drv[3]), .in_aim_y(drv[4]), .in_aim_z(drv[5]),
    .in_cross_x(drv[6]), .in_cross_y(drv[7]), .in_cross_z(drv[8]),
    .in_stop_x(drv[9]), .in_stop_y(drv[10]), .in_stop_z(drv[11]),
    .out_valid, .out_stall, .out_slope_altitude, .out_status,
    .mismatches, .pending
  );

  // receiver side: random stall, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        for (int k = 0; k < 300; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic coord_t rnd48();
    return COORD_W'({$urandom, $urandom});
  endfunction

  function automatic coord_t near(input coord_t base, input int bits);
    coord_t off;
    off = rnd48() >>> (COORD_W - bits);
    return base + off;
  endfunction

  task automatic send_points();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 12; k++) drv[k] <= pts[k];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic set_all(input coord_t v);
    for (int k = 0; k < 12; k++) pts[k] = v;
  endtask

  task automatic random_points();
    int kind;
    coord_t base;
    kind = $urandom_range(99);
    base = rnd48() >>> $urandom_range(0, 16);
    if (kind < 12) begin
      for (int k = 0; k < 12; k++) pts[k] = rnd48();
    end else begin
      for (int k = 0; k < 12; k++) pts[k] = near(base, $urandom_range(8, 34));
      if (kind < 18) pts[9] = pts[3];
      else if (kind < 24) for (int k = 0; k < 3; k++) pts[6+k] = pts[3+k];
      else if (kind < 28) begin
        pts[5] = $urandom_range(1) ? SAT_MAX - $urandom_range(3) : SAT_MIN + $urandom_range(3);
        pts[11] = pts[5] + (rnd48() >>> 8);
      end
    end
    send_points();
  endtask

  initial begin
    int phase_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, degenerate plane, zero run in x, saturation
    set_all(SAT_MAX); send_points();
    set_all(SAT_MIN); send_points();
    set_all('0); send_points();
    pts = '{SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN,
            SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX};
    send_points();
    pts = '{SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX,
            SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN};
    send_points();
    // collinear path points
    pts = '{48'sd5, 48'sd7, 48'sd9, 48'sd0, 48'sd0, 48'sd0,
            48'sd1, 48'sd2, 48'sd3, 48'sd2, 48'sd4, 48'sd6};
    send_points();
    // zero run in x
    pts = '{48'sd100, 48'sd3, 48'sd4, 48'sd0, 48'sd0, 48'sd0,
            48'sd1, 48'sd0, 48'sd0, 48'sd0, 48'sd1, 48'sd1};
    send_points();
    // ordinary slope, both signs of result
    pts = '{48'sd3 <<< 28, 48'sd1 <<< 28, 48'sd7 <<< 28, 48'sd0, 48'sd0, 48'sd1 <<< 28,
            48'sd0, 48'sd1 <<< 28, 48'sd0, 48'sd10 <<< 28, 48'sd0, -(48'sd1 <<< 28)};
    send_points();
    pts = '{-48'sd3, 48'sd2, 48'sd1, 48'sd0, 48'sd0, 48'sd0,
            48'sd0, 48'sd1, 48'sd0, 48'sd2, 48'sd0, 48'sd1};
    send_points();
    pts = '{-48'sd1, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
            48'sd0, 48'sd1, 48'sd0, 48'sd2, 48'sd0, 48'sd1};
    send_points();
    // saturation high and low
    pts = '{SAT_MAX, 48'sd0, 48'sd0, 48'sd0, 48'sd0, SAT_MAX - 48'sd2,
            48'sd0, 48'sd1, 48'sd0, 48'sd1, 48'sd0, 48'sd1000};
    send_points();
    pts = '{SAT_MAX, 48'sd0, 48'sd0, 48'sd0, 48'sd0, SAT_MIN + 48'sd2,
            48'sd0, 48'sd1, 48'sd0, 48'sd1, 48'sd0, -48'sd1000};
    send_points();
    // rounding of a fractional result, both signs
    pts = '{48'sd1, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
            48'sd0, 48'sd1, 48'sd0, 48'sd2, 48'sd0, 48'sd1};
    send_points();
    pts = '{48'sd1, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0,
            48'sd0, 48'sd1, 48'sd0, 48'sd2, 48'sd0, -48'sd1};
    send_points();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 9 : 0;
      phase_items = 0;
      while (phase_items < 600) begin
        if (phase == 1 && phase_items == 100) hold_req = 1'b1;
        random_points();
        phase_items++;
      end
      in_valid <= 1'b0;
      @(posedge clk);
      wait (pending == 0);
      @(posedge clk);
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/gsa_pkg.sv
src/gsa_mul.sv
src/gsa_div.sv
src/glide_slope_altitude.sv
bench/gsa_altitude_checker.sv
bench/tb_glide_slope_altitude.sv
